/* rtl/tcm_pkg.sv */
package tcm_pkg;

   localparam int unsigned DataWidth = 16;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned CsrAddrWidth = 3;

   localparam logic [CountWidth-1:0] MaxPoints = 4'd5;
   localparam logic [CountWidth-1:0] MaxPointsReset = 4'd5;

   localparam logic [CsrAddrWidth-1:0] CSR_SENSOR_MAX_X = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_SENSOR_MAX_Y = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_MAP_WIDTH = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_MAP_HEIGHT = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CSR_ROTATION = 3'd4;
   localparam logic [CsrAddrWidth-1:0] CSR_MAX_POINTS = 3'd5;

   localparam logic REQ_STATUS = 1'b0;
   localparam logic REQ_POINT = 1'b1;

   localparam logic [2:0] VERDICT_NOT_READY = 3'd0;
   localparam logic [2:0] VERDICT_OPENED = 3'd1;
   localparam logic [2:0] VERDICT_EMPTY = 3'd2;
   localparam logic [2:0] VERDICT_BAD_COUNT = 3'd3;
   localparam logic [2:0] VERDICT_STRAY = 3'd4;

   localparam logic [1:0] ROT_0 = 2'd0;
   localparam logic [1:0] ROT_90 = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [DataWidth-1:0] SatValue = 16'hFFFF;

   typedef struct packed {
      logic kind;
      logic [2:0] verdict;
      logic [CountWidth-1:0] point_count;
      logic [DataWidth-1:0] size;
      logic [7:0] id;
      logic point_valid;
      logic last;
      logic clear_status;
   } result_type;

endpackage

/* rtl/tcm_scale.sv */
module tcm_scale (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] value,
   input  logic [15:0] mult,
   input  logic [15:0] divisor,
   output logic        busy,
   output logic [15:0] result
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MUL = 2'd1;
   localparam logic [1:0] S_CHK = 2'd2;
   localparam logic [1:0] S_DIV = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] hi_ff, hi_in;
   logic [15:0] lo_ff, lo_in;
   logic [15:0] mult_ff, mult_in;
   logic [15:0] div_ff, div_in;
   logic [15:0] res_ff, res_in;

   logic [16:0] sum;
   logic [16:0] rem;
   logic [16:0] diff;
   logic        ge;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mult_ff} : 17'd0);
   assign rem = {hi_ff, lo_ff[15]};
   assign diff = rem - {1'b0, div_ff};
   assign ge = rem >= {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      hi_in = hi_ff;
      lo_in = lo_ff;
      mult_in = mult_ff;
      div_in = div_ff;
      res_in = res_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_MUL;
               cnt_in = 4'd0;
               hi_in = 16'd0;
               lo_in = value;
               mult_in = mult;
               div_in = divisor;
            end
         end
         S_MUL: begin
            hi_in = sum[16:1];
            lo_in = {sum[0], lo_ff[15:1]};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            cnt_in = 4'd0;
            if (div_ff == 16'd0) begin
               res_in = 16'd0;
               state_in = S_IDLE;
            end else if (hi_ff >= div_ff) begin
               res_in = tcm_pkg::SatValue;
               state_in = S_IDLE;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            hi_in = ge ? diff[15:0] : rem[15:0];
            lo_in = {lo_ff[14:0], ge};
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               res_in = {lo_ff[14:0], ge};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      mult_ff <= mult_in;
      div_ff <= div_in;
      res_ff <= res_in;
   end

   assign busy = state_ff != S_IDLE;
   assign result = res_ff;

endmodule

/* rtl/touch_report_coordinate_mapper.sv */
// Flow: a delivered point's result waits in the pending register for the bit-serial
// multiply and restoring divide (x and y in parallel); status items, stray records and
// records past the delivered count move on to the output register without that wait.
// Hand-off: one transaction is held at a time; the next is taken once the result moves to
// the output register, which it does only when that register is empty or being read.
// Reset: synchronous, active high; clears report state, loads register defaults.
module touch_report_coordinate_mapper (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_status_byte,
   input  logic [15:0] req_raw_x,
   input  logic [15:0] req_raw_y,
   input  logic [15:0] req_raw_size,
   input  logic [7:0]  req_track_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [2:0]  rsp_verdict,
   output logic [3:0]  rsp_point_count,
   output logic [15:0] rsp_out_x,
   output logic [15:0] rsp_out_y,
   output logic [15:0] rsp_out_size,
   output logic [7:0]  rsp_out_id,
   output logic        rsp_point_valid,
   output logic        rsp_last,
   output logic        rsp_clear_status,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   function automatic logic [15:0] floor_sub(input logic [15:0] a, input logic [15:0] b);
      floor_sub = (b > a) ? 16'd0 : a - b;
   endfunction

   logic [15:0] sensor_max_x_ff, sensor_max_x_in;
   logic [15:0] sensor_max_y_ff, sensor_max_y_in;
   logic [15:0] map_width_ff, map_width_in;
   logic [15:0] map_height_ff, map_height_in;
   logic [1:0]  rotation_ff, rotation_in;
   logic [3:0]  max_points_ff, max_points_in;

   logic [3:0]  records_left_ff, records_left_in;
   logic [3:0]  records_seen_ff, records_seen_in;
   logic [3:0]  deliver_count_ff, deliver_count_in;
   logic        report_open_ff, report_open_in;

   logic        pend_ff, pend_in;
   logic        pend_scale_ff, pend_scale_in;
   tcm_pkg::result_type pend_res_ff, pend_res_in;

   logic        rsp_valid_ff, rsp_valid_in;
   tcm_pkg::result_type rsp_res_ff, rsp_res_in;
   logic [15:0] rsp_x_ff, rsp_x_in;
   logic [15:0] rsp_y_ff, rsp_y_in;

   logic        accept;
   logic        scale_start;
   logic        busy_x, busy_y;
   logic [15:0] mx, my;
   logic [15:0] fx, fy;
   logic        move;
   logic [3:0]  cnt;
   logic [3:0]  dc;
   logic        deliver;

   assign req_ready = !pend_ff;
   assign accept = req_valid && req_ready;
   assign cnt = req_status_byte[3:0];
   assign dc = (cnt < max_points_ff) ? cnt : max_points_ff;
   assign deliver = records_seen_ff < deliver_count_ff;
   assign scale_start = accept && req_type == tcm_pkg::REQ_POINT && report_open_ff && deliver;
   assign move = pend_ff && !(pend_scale_ff && (busy_x || busy_y))
                 && (!rsp_valid_ff || rsp_ready);

   tcm_scale u_scale_x (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .value   (req_raw_x),
      .mult    (map_width_ff),
      .divisor (sensor_max_x_ff),
      .busy    (busy_x),
      .result  (mx)
   );

   tcm_scale u_scale_y (
      .clock   (clock),
      .reset   (reset),
      .start   (scale_start),
      .value   (req_raw_y),
      .mult    (map_height_ff),
      .divisor (sensor_max_y_ff),
      .busy    (busy_y),
      .result  (my)
   );

   always_comb begin
      case (rotation_ff)
         tcm_pkg::ROT_90: begin
            fx = my;
            fy = floor_sub(map_width_ff, mx);
         end
         tcm_pkg::ROT_180: begin
            fx = floor_sub(map_width_ff, mx);
            fy = floor_sub(map_height_ff, my);
         end
         tcm_pkg::ROT_270: begin
            fx = floor_sub(map_height_ff, my);
            fy = mx;
         end
         default: begin
            fx = mx;
            fy = my;
         end
      endcase
   end

   always_comb begin
      sensor_max_x_in = sensor_max_x_ff;
      sensor_max_y_in = sensor_max_y_ff;
      map_width_in = map_width_ff;
      map_height_in = map_height_ff;
      rotation_in = rotation_ff;
      max_points_in = max_points_ff;
      if (csr_we) begin
         unique case (csr_addr)
            tcm_pkg::CSR_SENSOR_MAX_X: sensor_max_x_in = csr_wdata;
            tcm_pkg::CSR_SENSOR_MAX_Y: sensor_max_y_in = csr_wdata;
            tcm_pkg::CSR_MAP_WIDTH:    map_width_in = csr_wdata;
            tcm_pkg::CSR_MAP_HEIGHT:   map_height_in = csr_wdata;
            tcm_pkg::CSR_ROTATION:     rotation_in = csr_wdata[1:0];
            tcm_pkg::CSR_MAX_POINTS:   max_points_in = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      records_left_in = records_left_ff;
      records_seen_in = records_seen_ff;
      deliver_count_in = deliver_count_ff;
      report_open_in = report_open_ff;
      pend_in = pend_ff;
      pend_scale_in = pend_scale_ff;
      pend_res_in = pend_res_ff;
      if (move) begin
         pend_in = 1'b0;
      end
      if (accept) begin
         pend_in = 1'b1;
         pend_scale_in = scale_start;
         pend_res_in = '0;
         if (req_type == tcm_pkg::REQ_STATUS) begin
            // drop any open report, judge the status afresh
            report_open_in = 1'b0;
            pend_res_in.kind = tcm_pkg::REQ_STATUS;
            if (!req_status_byte[7]) begin
               pend_res_in.verdict = tcm_pkg::VERDICT_NOT_READY;
            end else if (cnt == 4'd0) begin
               pend_res_in.verdict = tcm_pkg::VERDICT_EMPTY;
               pend_res_in.clear_status = 1'b1;
            end else if (cnt > tcm_pkg::MaxPoints) begin
               pend_res_in.verdict = tcm_pkg::VERDICT_BAD_COUNT;
               pend_res_in.clear_status = 1'b1;
            end else begin
               report_open_in = 1'b1;
               records_left_in = cnt;
               records_seen_in = 4'd0;
               deliver_count_in = dc;
               pend_res_in.verdict = tcm_pkg::VERDICT_OPENED;
               pend_res_in.point_count = dc;
            end
         end else if (!report_open_ff) begin
            pend_res_in.kind = tcm_pkg::REQ_POINT;
            pend_res_in.verdict = tcm_pkg::VERDICT_STRAY;
         end else begin
            pend_res_in.kind = tcm_pkg::REQ_POINT;
            pend_res_in.point_count = deliver_count_ff;
            if (deliver) begin
               pend_res_in.size = req_raw_size;
               pend_res_in.id = req_track_id;
               pend_res_in.point_valid = 1'b1;
            end
            if (records_left_ff <= 4'd1) begin
               pend_res_in.last = 1'b1;
               pend_res_in.clear_status = 1'b1;
               report_open_in = 1'b0;
               records_left_in = 4'd0;
            end else begin
               records_left_in = records_left_ff - 4'd1;
            end
            records_seen_in = records_seen_ff + 4'd1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in = rsp_res_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (move) begin
         rsp_valid_in = 1'b1;
         rsp_res_in = pend_res_ff;
         rsp_x_in = pend_scale_ff ? fx : 16'd0;
         rsp_y_in = pend_scale_ff ? fy : 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_max_x_ff <= 16'd0;
         sensor_max_y_ff <= 16'd0;
         map_width_ff <= 16'd0;
         map_height_ff <= 16'd0;
         rotation_ff <= tcm_pkg::ROT_0;
         max_points_ff <= tcm_pkg::MaxPointsReset;
         records_left_ff <= 4'd0;
         records_seen_ff <= 4'd0;
         deliver_count_ff <= 4'd0;
         report_open_ff <= 1'b0;
         pend_ff <= 1'b0;
         pend_scale_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sensor_max_x_ff <= sensor_max_x_in;
         sensor_max_y_ff <= sensor_max_y_in;
         map_width_ff <= map_width_in;
         map_height_ff <= map_height_in;
         rotation_ff <= rotation_in;
         max_points_ff <= max_points_in;
         records_left_ff <= records_left_in;
         records_seen_ff <= records_seen_in;
         deliver_count_ff <= deliver_count_in;
         report_open_ff <= report_open_in;
         pend_ff <= pend_in;
         pend_scale_ff <= pend_scale_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_res_ff <= pend_res_in;
      rsp_res_ff <= rsp_res_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_res_ff.kind;
   assign rsp_verdict = rsp_res_ff.verdict;
   assign rsp_point_count = rsp_res_ff.point_count;
   assign rsp_out_x = rsp_x_ff;
   assign rsp_out_y = rsp_y_ff;
   assign rsp_out_size = rsp_res_ff.size;
   assign rsp_out_id = rsp_res_ff.id;
   assign rsp_point_valid = rsp_res_ff.point_valid;
   assign rsp_last = rsp_res_ff.last;
   assign rsp_clear_status = rsp_res_ff.clear_status;

`ifndef SYNTH
   a_open_has_records: assert property (@(posedge clock) disable iff (reset)
      report_open_ff |-> records_left_ff != 4'd0)
      else $error("open report with no records left");

   a_deliver_bounded: assert property (@(posedge clock) disable iff (reset)
      deliver_count_ff <= tcm_pkg::MaxPoints)
      else $error("deliver count above limit");

   a_accept_pends: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff)
      else $error("accepted transaction not held");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      scale_start |=> busy_x && busy_y)
      else $error("scale units did not start");

   a_valid_point_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_res_ff.point_valid |->
         rsp_res_ff.kind == tcm_pkg::REQ_POINT
         && rsp_res_ff.verdict == tcm_pkg::VERDICT_NOT_READY)
      else $error("delivered point with wrong kind or verdict");
`endif

endmodule

/* verif/touch_report_coordinate_mapper_tb.sv */
`timescale 1ns / 1ps

module touch_report_coordinate_mapper_tb;

   localparam logic [tcm_pkg::CsrAddrWidth-1:0] CSR_UNMAPPED_6 = 3'd6;
   localparam logic [tcm_pkg::CsrAddrWidth-1:0] CSR_UNMAPPED_7 = 3'd7;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_POINT = 1'b1;

   localparam int StatusReadyBit = 7;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_RANDOM = 1;
   localparam int IDLE_BURSTY = 2;

   localparam int NumPhases = 10;
   localparam int TxnsPerPhase = 125;
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic       req_type;
      logic [7:0] status_byte;
      logic [15:0] raw_x;
      logic [15:0] raw_y;
      logic [15:0] raw_size;
      logic [7:0] track_id;
   } touch_txn_type;

   typedef struct packed {
      logic        kind;
      logic [2:0]  verdict;
      logic [3:0]  point_count;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] size;
      logic [7:0]  id;
      logic        point_valid;
      logic        last;
      logic        clear_status;
   } touch_result_type;

   typedef struct packed {
      bit                    is_csr;
      logic [tcm_pkg::CsrAddrWidth-1:0] addr;
      logic [15:0]           wdata;
      touch_txn_type         txn;
      bit                    typed;
      touch_result_type      result;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = 1'b0;
   logic [7:0]  req_status_byte = '0;
   logic [15:0] req_raw_x = '0;
   logic [15:0] req_raw_y = '0;
   logic [15:0] req_raw_size = '0;
   logic [7:0]  req_track_id = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [2:0]  rsp_verdict;
   logic [3:0]  rsp_point_count;
   logic [15:0] rsp_out_x;
   logic [15:0] rsp_out_y;
   logic [15:0] rsp_out_size;
   logic [7:0]  rsp_out_id;
   logic        rsp_point_valid;
   logic        rsp_last;
   logic        rsp_clear_status;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   logic [15:0] cfg_sensor_max_x = '0;
   logic [15:0] cfg_sensor_max_y = '0;
   logic [15:0] cfg_map_width = '0;
   logic [15:0] cfg_map_height = '0;
   logic [1:0]  cfg_rotation = tcm_pkg::ROT_0;
   logic [3:0]  cfg_max_points = tcm_pkg::MaxPointsReset;

   logic [3:0] records_left = '0;
   logic [3:0] records_seen = '0;
   logic [3:0] deliver_count = '0;
   logic       report_open = 1'b0;

   touch_result_type expected_q[$];
   stim_row_type     directed_q[$];
   int mismatch_count = 0;
   int txns_sent = 0;
   int req_mode = IDLE_RANDOM;
   int rsp_mode = IDLE_RANDOM;

   touch_report_coordinate_mapper i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_status_byte (req_status_byte),
      .req_raw_x       (req_raw_x),
      .req_raw_y       (req_raw_y),
      .req_raw_size    (req_raw_size),
      .req_track_id    (req_track_id),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_verdict     (rsp_verdict),
      .rsp_point_count (rsp_point_count),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_size    (rsp_out_size),
      .rsp_out_id      (rsp_out_id),
      .rsp_point_valid (rsp_point_valid),
      .rsp_last        (rsp_last),
      .rsp_clear_status(rsp_clear_status),
      .csr_we          (csr_we),
      .csr_addr        (csr_addr),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [15:0] scale_axis(input logic [15:0] value, input logic [15:0] span,
                                              input logic [15:0] target);
      logic [31:0] quotient;
      if (span == '0) begin
         return '0;
      end
      quotient = (32'(value) * 32'(target)) / 32'(span);
      return (quotient > 32'hFFFF) ? tcm_pkg::SatValue : quotient[15:0];
   endfunction

   function automatic logic [15:0] floor_sub(input logic [15:0] a, input logic [15:0] b);
      return (b > a) ? 16'd0 : a - b;
   endfunction

   function automatic touch_result_type map_transaction(input touch_txn_type t);
      touch_result_type r;
      logic [3:0]       touches;
      logic [15:0]      mx;
      logic [15:0]      my;
      r = '0;
      if (t.req_type == tcm_pkg::REQ_STATUS) begin
         touches = t.status_byte[3:0];
         report_open = 1'b0;
         r.kind = KIND_STATUS;
         if (!t.status_byte[StatusReadyBit]) begin
            r.verdict = tcm_pkg::VERDICT_NOT_READY;
         end else if (touches == '0) begin
            r.verdict = tcm_pkg::VERDICT_EMPTY;
            r.clear_status = 1'b1;
         end else if (touches > tcm_pkg::MaxPoints) begin
            r.verdict = tcm_pkg::VERDICT_BAD_COUNT;
            r.clear_status = 1'b1;
         end else begin
            deliver_count = (touches < cfg_max_points) ? touches : cfg_max_points;
            report_open = 1'b1;
            records_left = touches;
            records_seen = '0;
            r.verdict = tcm_pkg::VERDICT_OPENED;
            r.point_count = deliver_count;
         end
         return r;
      end
      r.kind = KIND_POINT;
      if (!report_open) begin
         r.verdict = tcm_pkg::VERDICT_STRAY;
         return r;
      end
      r.point_count = deliver_count;
      if (records_seen < deliver_count) begin
         mx = scale_axis(t.raw_x, cfg_sensor_max_x, cfg_map_width);
         my = scale_axis(t.raw_y, cfg_sensor_max_y, cfg_map_height);
         case (cfg_rotation)
            tcm_pkg::ROT_90: begin
               r.x = my;
               r.y = floor_sub(cfg_map_width, mx);
            end
            tcm_pkg::ROT_180: begin
               r.x = floor_sub(cfg_map_width, mx);
               r.y = floor_sub(cfg_map_height, my);
            end
            tcm_pkg::ROT_270: begin
               r.x = floor_sub(cfg_map_height, my);
               r.y = mx;
            end
            default: begin
               r.x = mx;
               r.y = my;
            end
         endcase
         r.size = t.raw_size;
         r.id = t.track_id;
         r.point_valid = 1'b1;
      end
      if (records_left <= 4'd1) begin
         r.last = 1'b1;
         r.clear_status = 1'b1;
         report_open = 1'b0;
         records_left = '0;
      end else begin
         records_left = records_left - 4'd1;
      end
      records_seen = records_seen + 4'd1;
      return r;
   endfunction

   function automatic int draw_wait(input int mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_BURSTY: return ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 19)) : 0;
         default: return int'($urandom_range(0, 19));
      endcase
   endfunction

   function automatic logic [15:0] pick_wide();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic touch_txn_type random_txn(input logic kind_sel);
      touch_txn_type t;
      t.req_type = kind_sel;
      t.status_byte = 8'($urandom);
      t.raw_x = pick_wide();
      t.raw_y = pick_wide();
      t.raw_size = pick_wide();
      t.track_id = 8'($urandom);
      return t;
   endfunction

   function automatic touch_result_type mk_result(input logic kind, input logic [2:0] verdict,
                                                  input logic [3:0] count, input logic [15:0] x,
                                                  input logic [15:0] y, input logic [15:0] size,
                                                  input logic [7:0] id, input logic pv,
                                                  input logic last, input logic clr);
      touch_result_type r;
      r.kind = kind;
      r.verdict = verdict;
      r.point_count = count;
      r.x = x;
      r.y = y;
      r.size = size;
      r.id = id;
      r.point_valid = pv;
      r.last = last;
      r.clear_status = clr;
      return r;
   endfunction

   function automatic stim_row_type csr_row(input logic [tcm_pkg::CsrAddrWidth-1:0] addr,
                                            input logic [15:0] data);
      stim_row_type row;
      row = '0;
      row.is_csr = 1'b1;
      row.addr = addr;
      row.wdata = data;
      return row;
   endfunction

   function automatic stim_row_type status_row(input logic [7:0] status, input bit typed,
                                               input touch_result_type res);
      stim_row_type row;
      row = '0;
      row.txn.req_type = tcm_pkg::REQ_STATUS;
      row.txn.status_byte = status;
      row.typed = typed;
      row.result = res;
      return row;
   endfunction

   function automatic stim_row_type point_row(input logic [15:0] x, input logic [15:0] y,
                                              input logic [15:0] size, input logic [7:0] id,
                                              input bit typed, input touch_result_type res);
      stim_row_type row;
      row = '0;
      row.txn.req_type = tcm_pkg::REQ_POINT;
      row.txn.raw_x = x;
      row.txn.raw_y = y;
      row.txn.raw_size = size;
      row.txn.track_id = id;
      row.typed = typed;
      row.result = res;
      return row;
   endfunction

   task automatic send_txn(input touch_txn_type t, input bit typed,
                           input touch_result_type res);
      int               gap;
      touch_result_type predicted;
      gap = draw_wait(req_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= t.req_type;
      req_status_byte <= t.status_byte;
      req_raw_x <= t.raw_x;
      req_raw_y <= t.raw_y;
      req_raw_size <= t.raw_size;
      req_track_id <= t.track_id;
      do @(posedge clock); while (!req_ready);
      predicted = map_transaction(t);
      expected_q.push_back(typed ? res : predicted);
      txns_sent++;
   endtask

   task automatic send_status(input logic [7:0] status);
      touch_txn_type t;
      t = random_txn(tcm_pkg::REQ_STATUS);
      t.status_byte = status;
      send_txn(t, 1'b0, '0);
   endtask

   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [tcm_pkg::CsrAddrWidth-1:0] addr,
                                 input logic [15:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         tcm_pkg::CSR_SENSOR_MAX_X: cfg_sensor_max_x = data;
         tcm_pkg::CSR_SENSOR_MAX_Y: cfg_sensor_max_y = data;
         tcm_pkg::CSR_MAP_WIDTH:    cfg_map_width = data;
         tcm_pkg::CSR_MAP_HEIGHT:   cfg_map_height = data;
         tcm_pkg::CSR_ROTATION:     cfg_rotation = data[1:0];
         tcm_pkg::CSR_MAX_POINTS:   cfg_max_points = data[3:0];
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result();
      touch_result_type want;
      if (expected_q.size() == 0) begin
         $error("result transaction with no pending request");
         mismatch_count++;
         return;
      end
      want = expected_q.pop_front();
      check_field("kind", 16'(want.kind), 16'(rsp_kind));
      check_field("verdict", 16'(want.verdict), 16'(rsp_verdict));
      check_field("point_count", 16'(want.point_count), 16'(rsp_point_count));
      check_field("out_x", want.x, rsp_out_x);
      check_field("out_y", want.y, rsp_out_y);
      check_field("out_size", want.size, rsp_out_size);
      check_field("out_id", 16'(want.id), 16'(rsp_out_id));
      check_field("point_valid", 16'(want.point_valid), 16'(rsp_point_valid));
      check_field("last", 16'(want.last), 16'(rsp_last));
      check_field("clear_status", 16'(want.clear_status), 16'(rsp_clear_status));
   endtask

   initial begin
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_wait(rsp_mode);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         check_result();
      end
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [3:0] touches;
      int         choice;
      int         npts;
      int         phase_end;

      // reset configuration: sensor spans zero, so every mapped coordinate is zero
      directed_q.push_back(point_row(16'd1234, 16'd5678, 16'h0042, 8'h11, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_STRAY, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0)));
      directed_q.push_back(status_row(8'h00, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_NOT_READY, '0, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(status_row(8'h7F, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_NOT_READY, '0, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(status_row(8'h80, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_EMPTY, '0, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b1)));
      directed_q.push_back(status_row(8'h86, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_BAD_COUNT, '0, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b1)));
      directed_q.push_back(status_row(8'h8F, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_BAD_COUNT, '0, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b1)));
      directed_q.push_back(status_row(8'h82, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_OPENED, 4'd2, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, 4'd2, '0, '0, 16'hFFFF, 8'hFF,
                   1'b1, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, 4'd2, '0, '0, '0, '0,
                   1'b1, 1'b1, 1'b1)));
      directed_q.push_back(status_row(8'hF5, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_OPENED, 4'd5, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'd100, 16'd200, 16'd300, 8'h01, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, 4'd5, '0, '0, 16'd300, 8'h01,
                   1'b1, 1'b0, 1'b0)));
      // drop the open report on a fresh status
      directed_q.push_back(status_row(8'h81, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_OPENED, 4'd1, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'd7, 16'd9, 16'h5A5A, 8'hA5, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, 4'd1, '0, '0, 16'h5A5A, 8'hA5,
                   1'b1, 1'b1, 1'b1)));

      // identity scale on x, saturation on y, one point delivered, then none with max points zero
      directed_q.push_back(csr_row(tcm_pkg::CSR_SENSOR_MAX_X, 16'hFFFF));
      directed_q.push_back(csr_row(tcm_pkg::CSR_SENSOR_MAX_Y, 16'h0001));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAP_WIDTH, 16'hFFFF));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAP_HEIGHT, 16'hFFFF));
      directed_q.push_back(csr_row(tcm_pkg::CSR_ROTATION, {14'h3FFF, tcm_pkg::ROT_0}));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAX_POINTS, 16'hFFF1));
      directed_q.push_back(csr_row(CSR_UNMAPPED_6, 16'hFFFF));
      directed_q.push_back(status_row(8'h82, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_OPENED, 4'd1, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'hABCD, 16'd2, 16'd7, 8'h80, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, 4'd1, 16'hABCD, 16'hFFFF, 16'd7,
                   8'h80, 1'b1, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, 4'd1, '0, '0, '0, '0,
                   1'b0, 1'b1, 1'b1)));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAX_POINTS, 16'h0000));
      directed_q.push_back(status_row(8'h81, 1'b1,
         mk_result(KIND_STATUS, tcm_pkg::VERDICT_OPENED, '0, '0, '0, '0, '0,
                   1'b0, 1'b0, 1'b0)));
      directed_q.push_back(point_row(16'h1234, 16'h4321, 16'h00FF, 8'h3C, 1'b1,
         mk_result(KIND_POINT, tcm_pkg::VERDICT_NOT_READY, '0, '0, '0, '0, '0,
                   1'b0, 1'b1, 1'b1)));

      // each quarter turn, including floored subtractions
      directed_q.push_back(csr_row(tcm_pkg::CSR_SENSOR_MAX_X, 16'd1000));
      directed_q.push_back(csr_row(tcm_pkg::CSR_SENSOR_MAX_Y, 16'd500));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAP_WIDTH, 16'd480));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAP_HEIGHT, 16'd320));
      directed_q.push_back(csr_row(tcm_pkg::CSR_MAX_POINTS, 16'h000F));
      directed_q.push_back(csr_row(tcm_pkg::CSR_ROTATION, {14'h0, tcm_pkg::ROT_90}));
      directed_q.push_back(status_row(8'h81, 1'b0, '0));
      directed_q.push_back(point_row(16'd500, 16'd250, 16'd9, 8'h03, 1'b0, '0));
      directed_q.push_back(csr_row(tcm_pkg::CSR_ROTATION, {14'h0, tcm_pkg::ROT_180}));
      directed_q.push_back(status_row(8'h81, 1'b0, '0));
      directed_q.push_back(point_row(16'd2000, 16'd1000, 16'd10, 8'h04, 1'b0, '0));
      directed_q.push_back(csr_row(tcm_pkg::CSR_ROTATION, {14'h0, tcm_pkg::ROT_270}));
      directed_q.push_back(status_row(8'h81, 1'b0, '0));
      directed_q.push_back(point_row(16'd250, 16'd125, 16'd11, 8'h05, 1'b0, '0));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_q[i]) begin
         if (directed_q[i].is_csr) begin
            settle();
            write_register(directed_q[i].addr, directed_q[i].wdata);
         end else begin
            send_txn(directed_q[i].txn, directed_q[i].typed, directed_q[i].result);
         end
      end

      for (int phase = 0; phase < NumPhases; phase++) begin
         settle();
         write_register(tcm_pkg::CSR_SENSOR_MAX_X, pick_wide());
         write_register(tcm_pkg::CSR_SENSOR_MAX_Y, pick_wide());
         write_register(tcm_pkg::CSR_MAP_WIDTH, pick_wide());
         write_register(tcm_pkg::CSR_MAP_HEIGHT, pick_wide());
         write_register(tcm_pkg::CSR_ROTATION, 16'($urandom));
         case ($urandom_range(0, 3))
            0: write_register(tcm_pkg::CSR_MAX_POINTS, {12'($urandom), 4'd0});
            1: write_register(tcm_pkg::CSR_MAX_POINTS, {12'($urandom), 4'd15});
            default: write_register(tcm_pkg::CSR_MAX_POINTS, 16'($urandom));
         endcase
         if ($urandom_range(0, 2) == 0) begin
            write_register($urandom_range(0, 1) ? CSR_UNMAPPED_7 : CSR_UNMAPPED_6,
                           16'($urandom));
         end
         req_mode = (phase % 3 == 0) ? IDLE_NONE
                                     : int'($urandom_range(IDLE_RANDOM, IDLE_BURSTY));
         rsp_mode = (phase % 4 == 1) ? IDLE_NONE
                                     : int'($urandom_range(IDLE_RANDOM, IDLE_BURSTY));
         phase_end = txns_sent + TxnsPerPhase;
         while (txns_sent < phase_end) begin
            choice = int'($urandom_range(0, 9));
            if (choice < 7) begin
               touches = 4'($urandom_range(1, tcm_pkg::MaxPoints));
               send_status({1'b1, 3'($urandom), touches});
               npts = (choice == 6) ? int'($urandom_range(0, int'(touches) + 2))
                                    : int'(touches);
               repeat (npts) send_txn(random_txn(tcm_pkg::REQ_POINT), 1'b0, '0);
            end else if (choice == 7) begin
               send_status(8'($urandom));
            end else if (choice == 8) begin
               send_txn(random_txn(tcm_pkg::REQ_POINT), 1'b0, '0);
            end else begin
               touches = $urandom_range(0, 1) ? 4'd0
                         : 4'($urandom_range(int'(tcm_pkg::MaxPoints) + 1, 15));
               send_status({1'b1, 3'($urandom), touches});
            end
         end
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
